// ===== rtl/core/slip_pkg.sv =====
// Package with the byte codes and widths of the SLIP frame decoder.
`timescale 1ns / 1ps

package slip_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;

    // Special bytes of the line encoding.
    localparam logic [BYTE_W-1:0] END_BYTE     = 8'hC0;
    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'hDB;
    localparam logic [BYTE_W-1:0] ESC_END_BYTE = 8'hDC;
    localparam logic [BYTE_W-1:0] ESC_ESC_BYTE = 8'hDD;

    // The decoded byte count saturates at the smaller of this and the field maximum.
    localparam int unsigned MAX_DECODED = 511;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_DECODED < COUNT_MAX) ? MAX_DECODED : COUNT_MAX);

    // Kinds of output beat.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

endpackage

// ===== rtl/core/slip_frame_decoder.sv =====
// SLIP frame decoder: unescapes frame bytes and reports an end-of-frame status.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one raw received byte per beat, with i_final_byte
// marking the last byte of a frame. A frame is valid when it is at least two
// bytes long and both its first and last bytes are 0xC0. Inner bytes are
// unescaped and sent out at once as data beats (o_item_kind 0), so the
// receiver must drop them when the closing status beat (o_item_kind 1)
// reports o_frame_valid 0. The status carries the saturating decoded length.
// Throughput: one input beat per cycle while the output does not stall; the
// escape state and count update in combinational logic in front of one output register.
// Output: a result is registered and appears on the output in the cycle after
// its input beat is accepted. Beats that produce no result (first byte, escape,
// stopped decoding) load nothing into the output register.
// Stall: while o_valid is high and i_stall is high the output register holds
// and o_stall is raised, so no input beat is accepted until the waiting
// result is taken; an empty output register never stalls the input.
// Reset: synchronous, active low; the block waits for the first byte of a
// new frame and the output register is emptied.
module slip_frame_decoder
    import slip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_frame_byte,
    input  logic               i_final_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_item_kind,
    output logic [BYTE_W-1:0]  o_data_out,
    output logic [COUNT_W-1:0] o_decoded_length,
    output logic               o_frame_valid
);

    // Frame decode state.
    logic               r_expect_first, n_expect_first;
    logic               r_start_bad, n_start_bad;
    logic               r_decode_stopped, n_decode_stopped;
    logic               r_escape_pending, n_escape_pending;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;

    // Output register.
    logic               r_out_valid;
    logic               r_item_kind;
    logic [BYTE_W-1:0]  r_data_out;
    logic [COUNT_W-1:0] r_decoded_length;
    logic               r_frame_valid;

    // Result of the current beat.
    logic               emit;
    logic               res_kind;
    logic [BYTE_W-1:0]  res_data;
    logic [COUNT_W-1:0] res_length;
    logic               res_valid;
    logic               out_free;
    logic               accept;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !out_free;
    assign accept   = i_valid && out_free;

    // Decode of one byte against the frame state.
    always_comb begin
        n_expect_first   = r_expect_first;
        n_start_bad      = r_start_bad;
        n_decode_stopped = r_decode_stopped;
        n_escape_pending = r_escape_pending;
        n_byte_count     = r_byte_count;
        emit             = 1'b0;
        res_kind         = KIND_DATA;
        res_data         = '0;
        res_length       = '0;
        res_valid        = 1'b0;

        if (r_expect_first) begin
            if (i_final_byte) begin
                // One-byte frame: invalid status, stay at frame start.
                emit     = 1'b1;
                res_kind = KIND_STATUS;
            end else begin
                n_expect_first   = 1'b0;
                n_start_bad      = (i_frame_byte != END_BYTE);
                n_decode_stopped = 1'b0;
                n_escape_pending = 1'b0;
                n_byte_count     = '0;
            end
        end else if (i_final_byte) begin
            // Closing byte: report status and return to frame start.
            emit             = 1'b1;
            res_kind         = KIND_STATUS;
            res_valid        = !r_start_bad && (i_frame_byte == END_BYTE);
            res_length       = res_valid ? r_byte_count : '0;
            n_expect_first   = 1'b1;
            n_start_bad      = 1'b0;
            n_decode_stopped = 1'b0;
            n_escape_pending = 1'b0;
            n_byte_count     = '0;
        end else if (!r_start_bad && !r_decode_stopped) begin
            if (r_escape_pending) begin
                n_escape_pending = 1'b0;
                emit             = 1'b1;
                case (i_frame_byte)
                    ESC_END_BYTE: res_data = END_BYTE;
                    ESC_ESC_BYTE: res_data = ESC_BYTE;
                    default:      res_data = i_frame_byte;
                endcase
            end else if (i_frame_byte == ESC_BYTE) begin
                n_escape_pending = 1'b1;
            end else if (i_frame_byte == END_BYTE) begin
                n_decode_stopped = 1'b1;
            end else begin
                emit     = 1'b1;
                res_data = i_frame_byte;
            end
            // Saturating count of decoded bytes.
            if (emit && (r_byte_count < COUNT_LIMIT)) begin
                n_byte_count = r_byte_count + COUNT_W'(1);
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first   <= 1'b1;
            r_start_bad      <= 1'b0;
            r_decode_stopped <= 1'b0;
            r_escape_pending <= 1'b0;
            r_byte_count     <= '0;
        end else if (accept) begin
            r_expect_first   <= n_expect_first;
            r_start_bad      <= n_start_bad;
            r_decode_stopped <= n_decode_stopped;
            r_escape_pending <= n_escape_pending;
            r_byte_count     <= n_byte_count;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= accept && emit;
        end
    end

    // Output payload; loaded only with a new result.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_item_kind      <= res_kind;
            r_data_out       <= res_data;
            r_decoded_length <= res_length;
            r_frame_valid    <= res_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_item_kind      = r_item_kind;
    assign o_data_out       = r_data_out;
    assign o_decoded_length = r_decoded_length;
    assign o_frame_valid    = r_frame_valid;

endmodule
